/* hdl/dsp_pkg.sv */
package dsp_pkg;

    localparam int NODE_BITS = 6;
    localparam int DIST_BITS = 48;
    localparam int WEIGHT_IN_BITS = 32;
    localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_RUN   = 2'd2;
    localparam logic [1:0] FUNC_QUERY = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [0:0] CFG_NODE_COUNT  = 1'd0;
    localparam logic [0:0] CFG_SOURCE_NODE = 1'd1;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_INIT   = 10'b00_0000_0010,
        S_SCAN   = 10'b00_0000_0100,
        S_PICK   = 10'b00_0000_1000,
        S_SETTLE = 10'b00_0001_0000,
        S_EDGE   = 10'b00_0010_0000,
        S_RELAX  = 10'b00_0100_0000,
        S_UPDATE = 10'b00_1000_0000,
        S_QUERY  = 10'b01_0000_0000,
        S_OUT    = 10'b10_0000_0000
    } state_t;

endpackage

/* hdl/dijkstra_shortest_paths_core.sv */
// Dijkstra single-source shortest path engine. Edges are loaded one per
// transaction into an edge RAM (a two-way edge writes two entries, the
// reverse one from a pending register); a run command then computes distances
// from source_node using one shared 48-bit add/compare unit. Node distances sit
// in a small RAM with registered reads; a per-node valid flag makes unwritten
// entries read as unreachable, so a run clears them all at once by resetting
// the flags. Clear, add edge and a run whose source is out of range go straight
// to the result state; a query first passes through a state that registers the
// read distance. A run otherwise settles the reachable nodes one by one:
// each settle step scans every node distance (scan and pick per node), then
// streams every stored edge (edge and relax per edge), with an update step for
// each edge leaving the settled node toward an active node.
// tready is low from acceptance until the result transaction completes.
module dijkstra_shortest_paths_core
    import dsp_pkg::*;
#(
    parameter int MAX_NODES   = 64,
    parameter int MAX_EDGES   = 1024,
    parameter int WEIGHT_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func[1:0], from_node[7:2], to_node[13:8], weight[45:14], both_ways[46],
    // query_node[52:47], zero fill
    input  logic [55:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], distance[49:2], reachable[50], answered_node[56:51], zero fill
    output logic [63:0]  m_tdata,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [6:0]   cfg_data
);

    localparam int NI_BITS = $clog2(MAX_NODES);
    localparam int NC_BITS = $clog2(MAX_NODES + 1);
    localparam int EA_BITS = $clog2(MAX_EDGES);
    localparam int EF_BITS = $clog2(MAX_EDGES + 1);
    localparam int E_WIDTH = 2 * NODE_BITS + WEIGHT_BITS;

    logic [1:0]                in_func;
    logic [NODE_BITS-1:0]      in_from, in_to, in_query;
    logic [WEIGHT_BITS-1:0]    in_weight;
    logic                      in_both;

    assign in_func   = s_tdata[1:0];
    assign in_from   = s_tdata[7:2];
    assign in_to     = s_tdata[13:8];
    assign in_weight = s_tdata[14 +: WEIGHT_BITS];
    assign in_both   = s_tdata[46];
    assign in_query  = s_tdata[52:47];

    logic [6:0]              node_count_reg;
    logic [NODE_BITS-1:0]    source_reg;
    logic [NC_BITS:0]        n_eff;

    always_comb begin
        if ({1'b0, node_count_reg} > 8'(MAX_NODES)) begin
            n_eff = (NC_BITS+1)'(MAX_NODES);
        end else begin
            n_eff = (NC_BITS+1)'(node_count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= 7'd64;
            source_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NODE_COUNT:  node_count_reg <= cfg_data;
                CFG_SOURCE_NODE: source_reg <= cfg_data[NODE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // node distances: RAM with registered read, valid and settled flags per node
    logic [DIST_BITS-1:0] dist_mem [MAX_NODES];
    logic [DIST_BITS-1:0] dist_rd_reg;
    logic                 dval_rd_reg;
    logic [MAX_NODES-1:0] dval_reg;
    logic [MAX_NODES-1:0] settled_reg;
    logic                 dist_we;
    logic [NI_BITS-1:0]   dist_waddr, dist_raddr;
    logic [DIST_BITS-1:0] dist_wdata, dist_eff;

    state_t                 state_reg;
    logic [EF_BITS-1:0]     fill_reg;
    logic [NC_BITS-1:0]     idx_reg;
    logic [EF_BITS-1:0]     eidx_reg;
    logic                   found_reg;
    logic [NI_BITS-1:0]     u_reg;
    logic [DIST_BITS-1:0]   best_reg;
    logic                   pend_reg;
    logic [NODE_BITS-1:0]   pend_from_reg, pend_to_reg;
    logic [WEIGHT_BITS-1:0] pend_w_reg;
    logic [NODE_BITS-1:0]   q_reg;
    logic [63:0]            out_reg;

    // edge RAM
    logic                   wr_en;
    logic [EA_BITS-1:0]     wr_addr, rd_addr;
    logic [E_WIDTH-1:0]     wr_data, rd_data;

    dsp_edge_ram #(
        .DEPTH(MAX_EDGES), .WIDTH(E_WIDTH), .ABITS(EA_BITS)
    ) u_ram (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    logic                   s_fire;
    assign s_tready = (state_reg == S_IDLE) && !pend_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = out_reg;

    logic [NODE_BITS-1:0] e_from, e_to;
    logic [WEIGHT_BITS-1:0] e_w;
    assign e_from = rd_data[NODE_BITS-1:0];
    assign e_to   = rd_data[2*NODE_BITS-1:NODE_BITS];
    assign e_w    = rd_data[2*NODE_BITS +: WEIGHT_BITS];

    // shared add/compare unit
    logic [DIST_BITS-1:0] op_a, op_b, cmp_b;
    logic [DIST_BITS:0]   sum;
    logic [DIST_BITS-1:0] sum_sat;
    logic                 less;
    logic [NI_BITS-1:0]   idx_n, to_n;

    assign idx_n = idx_reg[NI_BITS-1:0];
    assign to_n  = e_to[NI_BITS-1:0];

    always_comb begin
        case (state_reg)
            S_IDLE:  dist_raddr = in_query[NI_BITS-1:0];
            S_RELAX: dist_raddr = to_n;
            default: dist_raddr = idx_n;
        endcase
    end

    assign dist_we    = (state_reg == S_INIT) || ((state_reg == S_UPDATE) && less);
    assign dist_waddr = (state_reg == S_INIT) ? source_reg[NI_BITS-1:0] : to_n;
    assign dist_wdata = (state_reg == S_INIT) ? '0 : sum_sat;

    always_ff @(posedge aclk) begin
        if (dist_we) begin
            dist_mem[dist_waddr] <= dist_wdata;
        end
        dist_rd_reg <= dist_mem[dist_raddr];
        dval_rd_reg <= dval_reg[dist_raddr];
    end

    assign dist_eff = dval_rd_reg ? dist_rd_reg : DIST_INF;

    always_comb begin
        op_a  = dist_eff;
        op_b  = '0;
        cmp_b = best_reg;
        if (state_reg == S_UPDATE) begin
            op_a  = best_reg;
            op_b  = DIST_BITS'(e_w);
            cmp_b = dist_eff;
        end
    end
    assign sum     = {1'b0, op_a} + {1'b0, op_b};
    assign sum_sat = sum[DIST_BITS] ? DIST_INF : sum[DIST_BITS-1:0];
    assign less    = sum_sat < cmp_b;

    assign wr_data = pend_reg ? {pend_w_reg, pend_to_reg, pend_from_reg}
                              : {in_weight, in_to, in_from};
    assign wr_addr = fill_reg[EA_BITS-1:0];
    assign rd_addr = eidx_reg[EA_BITS-1:0];

    logic add_ok;
    logic [EF_BITS-1:0] need;
    assign need   = in_both ? EF_BITS'(2) : EF_BITS'(1);
    assign add_ok = ({2'b0, in_from} < 8'(n_eff)) && ({2'b0, in_to} < 8'(n_eff))
                    && (EF_BITS'(MAX_EDGES) - fill_reg >= need);
    assign wr_en  = pend_reg || (s_fire && in_func == FUNC_ADD && add_ok);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            settled_reg <= '0;
            dval_reg    <= '0;
        end else begin
            if (wr_en) fill_reg <= fill_reg + 1'b1;
            if (pend_reg) pend_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        out_reg <= '0;
                        q_reg   <= in_query;
                        case (in_func)
                            FUNC_CLEAR: begin
                                fill_reg  <= '0;
                                state_reg <= S_OUT;
                            end
                            FUNC_ADD: begin
                                if (({2'b0, in_from} >= 8'(n_eff))
                                        || ({2'b0, in_to} >= 8'(n_eff))) begin
                                    out_reg[1:0] <= ST_RANGE;
                                end else if (!add_ok) begin
                                    out_reg[1:0] <= ST_FULL;
                                end else if (in_both) begin
                                    pend_reg      <= 1'b1;
                                    pend_from_reg <= in_to;
                                    pend_to_reg   <= in_from;
                                    pend_w_reg    <= in_weight;
                                end
                                state_reg <= S_OUT;
                            end
                            FUNC_RUN: begin
                                settled_reg <= '0;
                                dval_reg    <= '0;
                                if ({2'b0, source_reg} >= 8'(n_eff)) begin
                                    out_reg[1:0] <= ST_RANGE;
                                    state_reg    <= S_OUT;
                                end else begin
                                    state_reg <= S_INIT;
                                end
                            end
                            default: state_reg <= S_QUERY;
                        endcase
                    end
                end
                S_INIT: begin
                    dval_reg[source_reg[NI_BITS-1:0]] <= 1'b1;
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    best_reg  <= DIST_INF;
                    state_reg <= S_SCAN;
                end
                S_SCAN: begin
                    if ({1'b0, idx_reg} < n_eff) begin
                        state_reg <= S_PICK;
                    end else begin
                        state_reg <= found_reg ? S_SETTLE : S_OUT;
                    end
                end
                S_PICK: begin
                    if (!settled_reg[idx_n] && less) begin
                        best_reg  <= dist_eff;
                        u_reg     <= idx_n;
                        found_reg <= 1'b1;
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_SCAN;
                end
                S_SETTLE: begin
                    settled_reg[u_reg] <= 1'b1;
                    eidx_reg  <= '0;
                    state_reg <= S_EDGE;
                end
                S_EDGE: begin
                    // RAM read latency: address presented, data next cycle
                    if (eidx_reg < fill_reg) begin
                        state_reg <= S_RELAX;
                    end else begin
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        best_reg  <= DIST_INF;
                        state_reg <= S_SCAN;
                    end
                end
                S_RELAX: begin
                    if (e_from == NODE_BITS'(u_reg) && {2'b0, e_to} < 8'(n_eff)) begin
                        state_reg <= S_UPDATE;
                    end else begin
                        eidx_reg  <= eidx_reg + 1'b1;
                        state_reg <= S_EDGE;
                    end
                end
                S_UPDATE: begin
                    if (less) begin
                        dval_reg[to_n] <= 1'b1;
                    end
                    eidx_reg  <= eidx_reg + 1'b1;
                    state_reg <= S_EDGE;
                end
                S_QUERY: begin
                    out_reg[56:51] <= q_reg;
                    if ({2'b0, q_reg} >= 8'(n_eff)) begin
                        out_reg[1:0]  <= ST_RANGE;
                        out_reg[49:2] <= DIST_INF;
                    end else begin
                        out_reg[49:2] <= dist_eff;
                        out_reg[50]   <= dist_eff != DIST_INF;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* hdl/dsp_edge_ram.sv */
module dsp_edge_ram
    import dsp_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 44,
    parameter int ABITS = 10
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [ABITS-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [ABITS-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* tb/tb.sv */
module tb;
    import dsp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NN = 64;
    localparam int NE = 1024;
    localparam longint LIMIT = 5000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // func, from_node, to_node, weight, both_ways, query_node, zero fill
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // status, distance, reachable, answered_node, zero fill
    logic [63:0] m_tdata;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [6:0]  cfg_data;

    dijkstra_shortest_paths_core dut (.*);

    typedef struct packed {
        logic [5:0]  qn;
        logic        two;
        logic [31:0] w;
        logic [5:0]  b;
        logic [5:0]  a;
        logic [1:0]  func;
    } cmd_t;

    typedef struct packed {
        logic [5:0]  node;
        logic        reach;
        logic [47:0] distance;
        logic [1:0]  status;
    } answer_t;

    typedef struct {
        cmd_t    c;
        bit      typed;
        answer_t r;
    } row_t;

    // predictor state
    logic [6:0]  m_count;
    logic [5:0]  m_source;
    logic [5:0]  e_from [NE];
    logic [5:0]  e_to [NE];
    logic [31:0] e_w [NE];
    int          e_fill;
    logic [47:0] n_dist [NN];
    bit          n_done [NN];

    answer_t answers_due[$];
    int errors, mism, n_sent, n_got;
    int idle_pct, stall_pct;
    bit hold_off;
    longint cyc = 0;

    function automatic answer_t predict_answer(cmd_t c);
        answer_t r;
        int n, u, v;
        logic [47:0] best;
        logic [48:0] nd;
        bit found;
        r = '0;
        n = (m_count > NN) ? NN : int'(m_count);
        case (c.func)
            FUNC_CLEAR: e_fill = 0;
            FUNC_ADD: begin
                if (c.a >= n || c.b >= n) r.status = ST_RANGE;
                else if (NE - e_fill < (c.two ? 2 : 1)) r.status = ST_FULL;
                else begin
                    e_from[e_fill] = c.a; e_to[e_fill] = c.b; e_w[e_fill] = c.w;
                    e_fill++;
                    if (c.two) begin
                        e_from[e_fill] = c.b; e_to[e_fill] = c.a; e_w[e_fill] = c.w;
                        e_fill++;
                    end
                end
            end
            FUNC_RUN: begin
                for (int i = 0; i < NN; i++) begin
                    n_dist[i] = DIST_INF;
                    n_done[i] = 0;
                end
                if (m_source >= n) r.status = ST_RANGE;
                else begin
                    n_dist[m_source] = '0;
                    forever begin
                        found = 0; best = DIST_INF; u = 0;
                        for (int i = 0; i < n; i++)
                            if (!n_done[i] && n_dist[i] < best) begin
                                best = n_dist[i]; u = i; found = 1;
                            end
                        if (!found) break;
                        n_done[u] = 1;
                        for (int e = 0; e < e_fill; e++) begin
                            v = int'(e_to[e]);
                            if (e_from[e] != u || v >= n) continue;
                            nd = {1'b0, best} + e_w[e];
                            if (nd > DIST_INF) nd = DIST_INF;
                            if (nd[47:0] < n_dist[v]) n_dist[v] = nd[47:0];
                        end
                    end
                end
            end
            default: begin
                r.node = c.qn;
                if (c.qn >= n) begin
                    r.status = ST_RANGE;
                    r.distance = DIST_INF;
                end else begin
                    r.distance = n_dist[c.qn];
                    r.reach = (r.distance != DIST_INF);
                end
            end
        endcase
        return r;
    endfunction

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("tb: timeout");
            $display("tb: errors");
            $finish;
        end
    end

    // result side
    always @(posedge aclk) begin
        answer_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = answer_t'(m_tdata[56:0]);
            n_got++;
            if (answers_due.size() == 0) begin
                errors++;
                if (mism++ < 10) $display("unexpected result %h", got);
            end else begin
                want = answers_due.pop_front();
                if (got.status !== want.status || got.distance !== want.distance ||
                    got.reach !== want.reach || got.node !== want.node) begin
                    errors++;
                    if (mism++ < 10)
                        $display({"mismatch: exp st=%0d d=%h r=%0d n=%0d",
                                  "  got st=%0d d=%h r=%0d n=%0d"},
                                 want.status, want.distance, want.reach, want.node,
                                 got.status, got.distance, got.reach, got.node);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_off) m_tready <= 0;
        else m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_cmd(cmd_t c, bit typed = 0, answer_t r = '0);
        answer_t p;
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tdata <= {3'b0, c};
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = predict_answer(c);
        if (typed && p !== r) begin
            errors++;
            $display("table row disagrees with predictor: %h vs %h", r, p);
        end
        answers_due.insert(answers_due.size(), p);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (answers_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_wr_en <= 1;
        @(negedge aclk);
        cfg_wr_en <= 0;
        if (idx == CFG_NODE_COUNT) m_count = val;
        else m_source = val[5:0];
    endtask

    function automatic cmd_t mk(logic [1:0] f, int a, int b, logic [31:0] w, bit two, int q);
        cmd_t c;
        c.func = f; c.a = 6'(a); c.b = 6'(b); c.w = w; c.two = two; c.qn = 6'(q);
        return c;
    endfunction

    function automatic answer_t ans(logic [1:0] st, logic [47:0] d, bit rc, int nd);
        answer_t r;
        r.status = st; r.distance = d; r.reach = rc; r.node = 6'(nd);
        return r;
    endfunction

    function automatic cmd_t rand_cmd(int n);
        cmd_t c;
        int k;
        c = cmd_t'(53'({$urandom, $urandom}));
        k = $urandom_range(99);
        c.func = k < 55 ? FUNC_ADD : k < 65 ? FUNC_RUN : k < 97 ? FUNC_QUERY : FUNC_CLEAR;
        if ($urandom_range(9) != 0) begin
            c.a = 6'($urandom_range(n - 1));
            c.b = 6'($urandom_range(n - 1));
            c.qn = 6'($urandom_range(n - 1));
        end
        case ($urandom_range(3))
            0: c.w = $urandom_range(15);
            1: c.w = 32'hffff_ffff - $urandom_range(3);
            default: ;
        endcase
        return c;
    endfunction

    task automatic random_phase(int items, int n);
        for (int i = 0; i < items; i++) send_cmd(rand_cmd(n));
    endtask

    row_t rows[$];
    int nc;

    initial begin
        s_tvalid = 0; s_tdata = '0;
        cfg_wr_en = 0; cfg_index = 0; cfg_data = '0;
        hold_off = 0; idle_pct = 0; stall_pct = 0;
        errors = 0; mism = 0; n_sent = 0; n_got = 0;
        m_count = 64; m_source = 0; e_fill = 0;
        for (int i = 0; i < NN; i++) begin
            n_dist[i] = DIST_INF;
            n_done[i] = 0;
        end
        aresetn = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        rows = '{
            '{mk(FUNC_QUERY, 0, 0, 0, 0, 5), 1, ans(ST_OK, DIST_INF, 0, 5)},
            '{mk(FUNC_RUN, 0, 0, 0, 0, 0), 1, ans(ST_OK, 0, 0, 0)},
            '{mk(FUNC_QUERY, 0, 0, 0, 0, 0), 1, ans(ST_OK, 0, 1, 0)},
            '{mk(FUNC_ADD, 0, 63, 32'hffffffff, 1, 0), 1, ans(ST_OK, 0, 0, 0)},
            '{mk(FUNC_ADD, 63, 62, 32'hffffffff, 0, 0), 0, '0},
            '{mk(FUNC_ADD, 0, 1, 7, 0, 0), 0, '0},
            '{mk(FUNC_ADD, 1, 2, 0, 1, 0), 0, '0},
            '{mk(FUNC_ADD, 0, 2, 7, 0, 0), 0, '0},
            '{mk(FUNC_RUN, 0, 0, 0, 0, 0), 0, '0},
            '{mk(FUNC_QUERY, 0, 0, 0, 0, 63), 1, ans(ST_OK, 48'hffffffff, 1, 63)},
            '{mk(FUNC_QUERY, 0, 0, 0, 0, 62), 1, ans(ST_OK, 48'h1fffffffe, 1, 62)},
            '{mk(FUNC_QUERY, 0, 0, 0, 0, 2), 1, ans(ST_OK, 7, 1, 2)},
            '{mk(FUNC_QUERY, 0, 0, 0, 0, 40), 1, ans(ST_OK, DIST_INF, 0, 40)},
            '{mk(FUNC_CLEAR, 0, 0, 0, 0, 0), 1, ans(ST_OK, 0, 0, 0)},
            '{mk(FUNC_QUERY, 0, 0, 0, 0, 2), 1, ans(ST_OK, 7, 1, 2)},
            '{mk(FUNC_RUN, 0, 0, 0, 0, 0), 0, '0},
            '{mk(FUNC_QUERY, 0, 0, 0, 0, 2), 1, ans(ST_OK, DIST_INF, 0, 2)}
        };
        foreach (rows[i]) send_cmd(rows[i].c, rows[i].typed, rows[i].r);
        drain();

        // small graph: range errors, stale edges, bad source
        write_reg(CFG_NODE_COUNT, 7'd4);
        write_reg(CFG_SOURCE_NODE, 7'd63);
        send_cmd(mk(FUNC_ADD, 4, 0, 1, 0, 0), 1, ans(ST_RANGE, 0, 0, 0));
        send_cmd(mk(FUNC_ADD, 0, 63, 1, 1, 0), 1, ans(ST_RANGE, 0, 0, 0));
        send_cmd(mk(FUNC_QUERY, 0, 0, 0, 0, 4), 1, ans(ST_RANGE, DIST_INF, 0, 4));
        send_cmd(mk(FUNC_RUN, 0, 0, 0, 0, 0), 1, ans(ST_RANGE, 0, 0, 0));
        drain();
        write_reg(CFG_SOURCE_NODE, 7'd1);
        send_cmd(mk(FUNC_ADD, 1, 3, 5, 1, 0));
        send_cmd(mk(FUNC_RUN, 0, 0, 0, 0, 0));
        send_cmd(mk(FUNC_QUERY, 0, 0, 0, 0, 3), 1, ans(ST_OK, 5, 1, 3));
        drain();
        write_reg(CFG_NODE_COUNT, 7'd0);
        send_cmd(mk(FUNC_QUERY, 0, 0, 0, 0, 0), 1, ans(ST_RANGE, DIST_INF, 0, 0));
        drain();
        write_reg(CFG_NODE_COUNT, 7'd127);
        send_cmd(mk(FUNC_CLEAR, 0, 0, 0, 0, 0));

        // fill the edge store to the end
        idle_pct = 0; stall_pct = 0;
        for (int i = 0; i < NE / 2 - 1; i++)
            send_cmd(mk(FUNC_ADD, $urandom_range(7), $urandom_range(7), $urandom, 1, 0));
        send_cmd(mk(FUNC_ADD, 0, 1, 3, 0, 0));
        send_cmd(mk(FUNC_ADD, 1, 2, 3, 1, 0), 1, ans(ST_FULL, 0, 0, 0));
        send_cmd(mk(FUNC_ADD, 1, 2, 3, 0, 0), 1, ans(ST_OK, 0, 0, 0));
        send_cmd(mk(FUNC_ADD, 1, 2, 3, 0, 0), 1, ans(ST_FULL, 0, 0, 0));
        send_cmd(mk(FUNC_CLEAR, 0, 0, 0, 0, 0));
        drain();

        // random phases over several settings and idling mixes
        for (int ph = 0; ph < 4; ph++) begin
            nc = ph == 0 ? 8 : ph == 1 ? 64 : ph == 2 ? 1 : 16;
            idle_pct = ph == 1 ? 87 : ph == 3 ? 9 : 0;
            stall_pct = ph == 2 ? 87 : ph == 3 ? 9 : 0;
            write_reg(CFG_NODE_COUNT, 7'(nc));
            write_reg(CFG_SOURCE_NODE, 7'($urandom_range(nc - 1)));
            random_phase(25, nc);
            drain();
        end

        // receiver holds off while commands keep coming
        idle_pct = 0; stall_pct = 0;
        fork
            begin
                hold_off = 1;
                repeat (300) @(negedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 10; i++)
                send_cmd(mk(FUNC_QUERY, 0, 0, 0, 0, $urandom_range(15)));
        join
        drain();

        $display("tb: %0d commands sent, %0d results checked; node counts 0..127,",
                 n_sent, n_got);
        $display("tb: range, full-store, stale-edge and saturation cases with stalls");
        if (errors == 0 && answers_due.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
